### hdl/crd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg
// shared types, constants and register indexes for the clipping run detector
// ----------------------------------------------------------------------------
package crd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 32;

   localparam int CFG_BITS       = 16;
   localparam int OUT_BITS       = 32;
   localparam int OUT_FIELDS     = 4;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STOP_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_LEVEL      = 2'd2;

   localparam logic [CFG_BITS-1:0] START_THRESHOLD_RESET = 16'd3;
   localparam logic [CFG_BITS-1:0] STOP_THRESHOLD_RESET  = 16'd3;
   localparam logic [CFG_BITS-1:0] CLIP_LEVEL_RESET      = 16'd32767;

   localparam int QUEUE_DEPTH = 2;

   // one classified sample, front to back
   typedef struct packed {
      logic track_start;
      logic clipped;
   } item_type;

endpackage
`default_nettype wire

### hdl/clipping_run_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipping_run_detector
// finds runs of clipped audio samples and reports each run closed by quiet samples; a track start drops an open run
// ----------------------------------------------------------------------------
//
//   channel   direction  transfer when            payload
//   req_*     in         req_tvalid & req_tready  tdata: sample; tuser: track_start
//   rsp_*     out        rsp_tvalid & rsp_tready  tdata: run_start, run_end,
//                                                 clipped_samples, run_length
//   csr_*     in         csr_valid & csr_ready    csr_index, csr_wdata
//
// one sample per cycle sustained while rsp is not stalled; the run counters in the back update
// once per sample, which sets the rate
// at the earliest, the closing sample's transfer writes the queue, and its run update then
// loads the output register and raises rsp_tvalid
// reset is synchronous: queue empty, run state and position zero, registers to
// their defaults; no clearing pass
// a stalled rsp holds the back, the two-entry queue absorbs the front, and
// req_tready falls only when the queue is full
//
module clipping_run_detector #(
   parameter int SAMPLE_BITS = crd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = crd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // sample input
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,  // sample, zero pad
   input  wire logic                                     req_tuser,  // track_start
   // run reports
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // run_start, run_end, clipped_samples, run_length (32 bits each)
   output logic [crd_pkg::OUT_FIELDS*crd_pkg::OUT_BITS-1:0] rsp_tdata,
   // register writes
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [crd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [crd_pkg::CFG_BITS-1:0]             csr_wdata
);

   logic [crd_pkg::CFG_BITS-1:0] start_threshold_ff;
   logic [crd_pkg::CFG_BITS-1:0] stop_threshold_ff;
   logic [crd_pkg::CFG_BITS-1:0] clip_level_ff;

   logic              item_valid;
   logic              item_ready;
   crd_pkg::item_type item;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_threshold_ff <= crd_pkg::START_THRESHOLD_RESET;
         stop_threshold_ff  <= crd_pkg::STOP_THRESHOLD_RESET;
         clip_level_ff      <= crd_pkg::CLIP_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crd_pkg::CSR_START_THRESHOLD: begin
               start_threshold_ff <= csr_wdata;
            end
            crd_pkg::CSR_STOP_THRESHOLD: begin
               stop_threshold_ff <= csr_wdata;
            end
            crd_pkg::CSR_CLIP_LEVEL: begin
               clip_level_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // front: classify against clip level and queue
   crd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .clip_level  (clip_level_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .track_start (req_tuser),
      .item_valid  (item_valid),
      .item        (item),
      .item_ready  (item_ready)
   );

   // back: run state and report register
   crd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .start_threshold (start_threshold_ff),
      .stop_threshold  (stop_threshold_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_ready      (item_ready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

   // a waiting report blocks the back from taking another item
   a_back_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !(item_valid && item_ready))
      else $error("back consumed an item while a report was stalled");

   // every report covers at least one clipped sample
   a_report_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3*crd_pkg::OUT_BITS-1:2*crd_pkg::OUT_BITS] != '0))
      else $error("report with zero clipped samples");

   // an accepted sample is visible to the back on the next cycle
   a_queue_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> item_valid)
      else $error("accepted sample missing from queue");

endmodule
`default_nettype wire

### hdl/crd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crd_front
// accepts samples, classifies them as clipped and queues them for the back
// ----------------------------------------------------------------------------
module crd_front #(
   parameter int SAMPLE_BITS = crd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [crd_pkg::CFG_BITS-1:0]  clip_level,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic                          track_start,
   output logic                               item_valid,
   output crd_pkg::item_type                  item,
   input  wire logic                          item_ready
);

   localparam int DEPTH     = crd_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CMP_BITS  = (SAMPLE_BITS > crd_pkg::CFG_BITS) ? SAMPLE_BITS
                                                                : crd_pkg::CFG_BITS;

   logic [SAMPLE_BITS-1:0] magnitude;
   logic                   clipped;
   crd_pkg::item_type      new_item;

   crd_pkg::item_type      entries_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   push, pop;

   // magnitude of the most negative code is its unsigned pattern
   always_comb begin
      magnitude = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
      clipped   = CMP_BITS'(magnitude) >= CMP_BITS'(clip_level);
      new_item.clipped     = clipped;
      new_item.track_start = track_start;
   end

   assign req_tready = count_ff != CNT_BITS'(DEPTH);
   assign item_valid = count_ff != '0;
   assign item       = entries_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

### hdl/crd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crd_back
// run tracking state, report formation and the result output register
// ----------------------------------------------------------------------------
module crd_back #(
   parameter int COUNT_BITS = crd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic [crd_pkg::CFG_BITS-1:0]                     start_threshold,
   input  wire logic [crd_pkg::CFG_BITS-1:0]                     stop_threshold,
   input  wire logic                                             item_valid,
   input  wire crd_pkg::item_type                                item,
   output logic                                                  item_ready,
   output logic                                                  rsp_tvalid,
   input  wire logic                                             rsp_tready,
   output logic [crd_pkg::OUT_FIELDS*crd_pkg::OUT_BITS-1:0]      rsp_tdata
);

   localparam int OB   = crd_pkg::OUT_BITS;
   localparam int CB   = crd_pkg::CFG_BITS;
   localparam int WIDE = (COUNT_BITS > OB) ? COUNT_BITS : OB;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_sub(input logic [COUNT_BITS-1:0] a,
                                                     input logic [CB-1:0] b);
      logic [COUNT_BITS-1:0] bx;
      bx = COUNT_BITS'(b);
      return (a > bx) ? a - bx : '0;
   endfunction

   function automatic logic [OB-1:0] to_out(input logic [COUNT_BITS-1:0] v);
      logic [WIDE-1:0] x;
      x = WIDE'(v);
      return (x > WIDE'({OB{1'b1}})) ? {OB{1'b1}} : x[OB-1:0];
   endfunction

   logic [COUNT_BITS-1:0] position_ff, position_in;
   logic [COUNT_BITS-1:0] clipped_ff, clipped_in;
   logic [CB-1:0]         quiet_ff, quiet_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] begin_ff, begin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [crd_pkg::OUT_FIELDS*OB-1:0] rsp_data_ff, rsp_data_in;

   logic [CB-1:0]         st, sp, quiet_inc;
   logic [COUNT_BITS-1:0] cur, cc, rt, rb, total_inc;
   logic [CB-1:0]         qc;
   logic                  pop, emit;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      st   = (start_threshold == '0) ? CB'(1) : start_threshold;
      sp   = (stop_threshold == '0) ? CB'(1) : stop_threshold;
      // track start clears position and run state before the sample counts
      cur  = item.track_start ? '0 : position_ff;
      cc   = item.track_start ? '0 : clipped_ff;
      qc   = item.track_start ? '0 : quiet_ff;
      rt   = item.track_start ? '0 : total_ff;
      rb   = item.track_start ? '0 : begin_ff;
      quiet_inc = (&qc) ? qc : qc + 1'b1;
      total_inc = sat_inc(rt);
      emit = 1'b0;

      clipped_in = cc;
      quiet_in   = qc;
      total_in   = rt;
      begin_in   = rb;
      rsp_data_in = {to_out(sat_sub(total_inc, sp)), to_out(cc),
                     to_out(sat_sub(cur, sp)), to_out(rb)};

      if (item.clipped) begin
         clipped_in = sat_inc(cc);
         if (cc == '0) begin
            begin_in = cur;
            total_in = COUNT_BITS'(1);
         end else begin
            quiet_in = '0;
            total_in = total_inc;
         end
      end else if (cc >= COUNT_BITS'(st)) begin
         if (quiet_inc >= sp) begin
            emit       = 1'b1;
            clipped_in = '0;
            quiet_in   = '0;
            total_in   = '0;
            begin_in   = '0;
         end else begin
            quiet_in = quiet_inc;
            total_in = total_inc;
         end
      end else begin
         clipped_in = '0;
      end

      position_in = sat_inc(cur);

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         clipped_ff   <= '0;
         quiet_ff     <= '0;
         total_ff     <= '0;
         begin_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            position_ff <= position_in;
            clipped_ff  <= clipped_in;
            quiet_ff    <= quiet_in;
            total_ff    <= total_in;
            begin_ff    <= begin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire
